// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/efo_pkg.sv -----
// ----------------------------------------------------------------------------
// efo_pkg
// Types, codes and SHA-1 constants for the font obfuscation block.
// ----------------------------------------------------------------------------
package efo_pkg;

    localparam int KEY_BYTES    = 64;
    localparam int KEY_AW       = 6;
    localparam int POS_W        = 11;
    localparam int DIDX_W       = 5;
    localparam int DIGEST_BYTES = 20;
    localparam int CNT_W        = 7;

    localparam logic [CNT_W-1:0]  LOAD_LAST   = 7'd64;
    localparam logic [CNT_W-1:0]  ROUND_LAST  = 7'd79;
    localparam logic [KEY_AW-1:0] LEN_HI_BYTE = 6'd62;
    localparam logic [KEY_AW-1:0] LEN_LO_BYTE = 6'd63;
    localparam logic [7:0]        PAD_BYTE    = 8'h80;

    // input selector codes
    localparam logic [1:0] MODE_KEY  = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_FONT = 2'd2;

    // result kinds
    localparam logic KIND_FONT   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [31:0] t_word;

    localparam t_word SHA_H0 = 32'h67452301;
    localparam t_word SHA_H1 = 32'hefcdab89;
    localparam t_word SHA_H2 = 32'h98badcfe;
    localparam t_word SHA_H3 = 32'h10325476;
    localparam t_word SHA_H4 = 32'hc3d2e1f0;

    typedef struct packed {
        logic              start;
        logic [KEY_AW-1:0] len;
    } t_core_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    function automatic t_word sha_k(input logic [CNT_W-1:0] t);
        t_word k;
        if (t < 7'd20)      k = 32'h5a827999;
        else if (t < 7'd40) k = 32'h6ed9eba1;
        else if (t < 7'd60) k = 32'h8f1bbcdc;
        else                k = 32'hca62c1d6;
        return k;
    endfunction

    function automatic t_word sha_f(input logic [CNT_W-1:0] t, input t_word x,
                                    input t_word y, input t_word z);
        t_word f;
        if (t < 7'd20)      f = (x & y) ^ (~x & z);
        else if (t < 7'd40) f = x ^ y ^ z;
        else if (t < 7'd60) f = (x & y) ^ (x & z) ^ (y & z);
        else                f = x ^ y ^ z;
        return f;
    endfunction

endpackage

// ----- sv/efo_ram.sv -----
// ----------------------------------------------------------------------------
// efo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/efo_sha1_core.sv -----
// ----------------------------------------------------------------------------
// efo_sha1_core
// Single-block SHA-1: streams the key bytes out of the key RAM into a
// 16-word schedule window, pads on the fly, then runs one round per cycle.
// ----------------------------------------------------------------------------
module efo_sha1_core
    import efo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_core_req         i_req,
    input  logic [7:0]        i_rdata,
    output logic [KEY_AW-1:0] o_raddr,
    output t_core_stat        o_stat,
    output t_word [4:0]       o_digest
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [KEY_AW-1:0] r_len, n_len;
    logic [511:0]      r_win, n_win;
    t_word             r_a, r_b, r_c, r_d, r_e;
    t_word             n_a, n_b, n_c, n_d, n_e;

    logic [KEY_AW-1:0] ld_idx;
    logic [7:0]        ld_byte;
    t_word             w0, w2, w8, w13, sched, tmp;

    // byte index of the RAM data arriving this cycle
    assign ld_idx  = r_cnt[KEY_AW-1:0] - 6'd1;
    assign o_raddr = r_cnt[KEY_AW-1:0];

    always_comb begin
        if (ld_idx < r_len) begin
            ld_byte = i_rdata;
        end else if (ld_idx == r_len) begin
            ld_byte = PAD_BYTE;
        end else if (ld_idx == LEN_HI_BYTE) begin
            ld_byte = {7'd0, r_len[5]};
        end else if (ld_idx == LEN_LO_BYTE) begin
            ld_byte = {r_len[4:0], 3'd0};
        end else begin
            ld_byte = 8'd0;
        end
    end

    assign w0    = r_win[511:480];
    assign w2    = r_win[447:416];
    assign w8    = r_win[255:224];
    assign w13   = r_win[95:64];
    assign sched = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                    w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};
    assign tmp   = {r_a[26:0], r_a[31:27]} + sha_f(r_cnt, r_b, r_c, r_d) + r_e
                   + sha_k(r_cnt) + w0;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_win   = r_win;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_e     = r_e;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_len   = i_req.len;
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (r_cnt != '0) begin
                    n_win = {r_win[503:0], ld_byte};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == LOAD_LAST) begin
                    n_cnt   = '0;
                    n_a     = SHA_H0;
                    n_b     = SHA_H1;
                    n_c     = SHA_H2;
                    n_d     = SHA_H3;
                    n_e     = SHA_H4;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_win = {r_win[479:0], sched};
                n_e   = r_d;
                n_d   = r_c;
                n_c   = {r_b[1:0], r_b[31:2]};
                n_b   = r_a;
                n_a   = tmp;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == ROUND_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_len <= n_len;
        r_win <= n_win;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_FIN);

    assign o_digest[0] = SHA_H0 + r_a;
    assign o_digest[1] = SHA_H1 + r_b;
    assign o_digest[2] = SHA_H2 + r_c;
    assign o_digest[3] = SHA_H3 + r_d;
    assign o_digest[4] = SHA_H4 + r_e;

endmodule

// ----- sv/epub_font_obfuscator_sha1.sv -----
// ----------------------------------------------------------------------------
// epub_font_obfuscator_sha1
// Font obfuscation with a SHA-1 key taken from a one-block identifier.
//
// Usage: requests come in on the s_axis channel, tuser selecting the kind:
// identifier byte, identifier end, or font byte (tdata holds the byte).
// Identifier bytes go into a 64-entry byte RAM; beyond MAX_KEY_BYTES they are
// dropped and the overflow flag is set. They give no result. A font byte
// gives one result on m_axis in the cycle after acceptance, XORed with the
// digest byte for its position while below OBFUSCATED_BYTES; font bytes
// stream at one per cycle while the receiver takes each result. An
// identifier end reads the key RAM out and runs 80 SHA-1 rounds, one per
// cycle in the core, then posts a status result with the overflow flag;
// s_axis_tready is low from the request until that result is posted.
// Results sit in one output register; a stalled receiver holds it and the
// block takes a new request once it is taken.
// Reset empties the output, clears the digest to zero (font bytes pass
// unchanged), the key length, overflow flag and position. The key RAM needs
// no clearing: only entries below the key length are read.
// ----------------------------------------------------------------------------
module epub_font_obfuscator_sha1
    import efo_pkg::*;
#(
    parameter int OBFUSCATED_BYTES = 1040,
    parameter int MAX_KEY_BYTES    = 55
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,  // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] key_error, rest zero
    output logic [0:0]  m_axis_tuser   // [0] kind
);

    logic              in_acc, out_free;
    logic [KEY_AW-1:0] r_len;
    logic              r_ovf;
    logic [POS_W-1:0]  r_pos;
    logic [DIDX_W-1:0] r_didx;
    t_word [4:0]       r_dig;
    logic              r_ovalid;
    logic              r_okind;
    logic [7:0]        r_obyte;
    logic              r_oerr;

    t_core_req         core_req;
    t_core_stat        core_stat;
    t_word [4:0]       core_dig;
    logic [KEY_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              key_we;

    t_word             dig_word;
    logic [7:0]        dig_byte;
    logic              in_range;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !core_stat.busy && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign key_we         = in_acc && (s_axis_tuser == MODE_KEY) &&
                            (r_len < KEY_AW'(MAX_KEY_BYTES));
    assign core_req.start = in_acc && (s_axis_tuser == MODE_END);
    assign core_req.len   = r_len;

    efo_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_len),
        .i_wdata (s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    efo_sha1_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (core_req),
        .i_rdata  (ram_rdata),
        .o_raddr  (ram_raddr),
        .o_stat   (core_stat),
        .o_digest (core_dig)
    );

    always_comb begin
        case (r_didx[4:2])
            3'd0:    dig_word = r_dig[0];
            3'd1:    dig_word = r_dig[1];
            3'd2:    dig_word = r_dig[2];
            3'd3:    dig_word = r_dig[3];
            3'd4:    dig_word = r_dig[4];
            default: dig_word = '0;
        endcase
        case (r_didx[1:0])
            2'd0:    dig_byte = dig_word[31:24];
            2'd1:    dig_byte = dig_word[23:16];
            2'd2:    dig_byte = dig_word[15:8];
            default: dig_byte = dig_word[7:0];
        endcase
    end

    assign in_range = (r_pos < POS_W'(OBFUSCATED_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_didx   <= '0;
            r_dig    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (in_acc && (s_axis_tuser == MODE_KEY)) begin
                if (r_len < KEY_AW'(MAX_KEY_BYTES)) begin
                    r_len <= r_len + 6'd1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (in_acc && (s_axis_tuser == MODE_FONT)) begin
                r_ovalid <= 1'b1;
                if (in_range) begin
                    r_pos  <= r_pos + 11'd1;
                    r_didx <= (r_didx == DIDX_W'(DIGEST_BYTES - 1)) ? '0 : r_didx + 5'd1;
                end
            end else if (core_stat.done) begin
                r_ovalid <= 1'b1;
                r_dig    <= core_dig;
                r_len    <= '0;
                r_ovf    <= 1'b0;
                r_pos    <= '0;
                r_didx   <= '0;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == MODE_FONT)) begin
            r_okind <= KIND_FONT;
            r_obyte <= in_range ? (s_axis_tdata ^ dig_byte) : s_axis_tdata;
            r_oerr  <= 1'b0;
        end else if (core_stat.done) begin
            r_okind <= KIND_STATUS;
            r_obyte <= 8'd0;
            r_oerr  <= r_ovf;
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = {7'd0, r_oerr, r_obyte};
    assign m_axis_tuser[0] = r_okind;

endmodule

// ----- sv/efo_checker.sv -----
// ----------------------------------------------------------------------------
// efo_checker
// Port-level checks for the font obfuscation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efo_checker
    import efo_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic end_acc;
    logic unused_data;

    assign end_acc     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_END);
    assign unused_data = ^s_axis_tdata;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser), "result changed while stalled")
    `ASSERT_CLK(a_status_zero, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[0] == KIND_STATUS) |-> m_axis_tdata[7:0] == 8'd0,
        "status result carries a data byte")
    `ASSERT_CLK(a_font_noerr, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tuser[0] == KIND_FONT) |-> m_axis_tdata[15:8] == 8'd0,
        "font result carries an error flag")
    `ASSERT_CLK(a_hash_stall, i_clk, i_rst_n,
        end_acc && !unused_data || end_acc && unused_data |=> !s_axis_tready,
        "request taken while hashing")
    `ASSERT_ALWAYS(a_rst_empty, i_clk,
        !i_rst_n |=> !m_axis_tvalid, "result pending after reset")

endmodule

bind epub_font_obfuscator_sha1 efo_checker u_efo_checker (.*);
